[design/pmdb_pkg.sv]
package pmdb_pkg;

    typedef logic signed [15:0] db_t;
    typedef logic        [2:0]  band_t;
    typedef logic        [13:0] falloff_t;
    typedef logic        [15:0] level_t;
    typedef logic        [15:0] defl_t;

    typedef struct packed {
        band_t band;
        db_t   held_db;
    } pmdb_beat_t;

    localparam db_t          DB_FLOOR      = 16'sh8000;
    localparam logic [10:0]  OCTAVE_DB     = 11'd1541;
    localparam falloff_t     FALLOFF_RESET = 14'd1336;

    localparam logic [23:0]  DIV230_MULT   = 24'd9336886;
    localparam int           DIV230_SHIFT  = 31;
    localparam logic [6:0]   ROUND_115     = 7'd115;

    function automatic logic [10:0] mant_db(input logic [5:0] idx);
        logic [10:0] t;
        case (idx)
            6'd0:  t = 11'd0;
            6'd1:  t = 11'd68;
            6'd2:  t = 11'd135;
            6'd3:  t = 11'd199;
            6'd4:  t = 11'd262;
            6'd5:  t = 11'd323;
            6'd6:  t = 11'd382;
            6'd7:  t = 11'd440;
            6'd8:  t = 11'd496;
            6'd9:  t = 11'd551;
            6'd10: t = 11'd605;
            6'd11: t = 11'd657;
            6'd12: t = 11'd708;
            6'd13: t = 11'd758;
            6'd14: t = 11'd807;
            6'd15: t = 11'd855;
            6'd16: t = 11'd902;
            6'd17: t = 11'd947;
            6'd18: t = 11'd992;
            6'd19: t = 11'd1036;
            6'd20: t = 11'd1080;
            6'd21: t = 11'd1122;
            6'd22: t = 11'd1163;
            6'd23: t = 11'd1204;
            6'd24: t = 11'd1244;
            6'd25: t = 11'd1284;
            6'd26: t = 11'd1322;
            6'd27: t = 11'd1360;
            6'd28: t = 11'd1398;
            6'd29: t = 11'd1435;
            6'd30: t = 11'd1471;
            6'd31: t = 11'd1506;
            6'd32: t = 11'd1541;
            default: t = 11'd0;
        endcase
        return t;
    endfunction

endpackage

[design/pmdb_log.sv]
module pmdb_log (
    input  pmdb_pkg::level_t level,
    output pmdb_pkg::db_t    db
);
    import pmdb_pkg::*;

    logic        [3:0]  lead;
    logic        [15:0] norm;
    logic        [4:0]  idx;
    logic        [9:0]  frac;
    logic        [10:0] t_lo;
    logic        [10:0] t_hi;
    logic        [6:0]  t_diff;
    logic        [16:0] interp;
    logic        [17:0] interp_rnd;
    logic signed [5:0]  oct;
    logic signed [16:0] db_oct;
    logic signed [16:0] db_sum;

    always_comb begin
        lead = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (level[i]) begin
                lead = 4'(i);
            end
        end
    end

    assign norm       = level << (4'd15 - lead);
    assign idx        = norm[14:10];
    assign frac       = norm[9:0];
    assign t_lo       = mant_db({1'b0, idx});
    assign t_hi       = mant_db(6'({1'b0, idx} + 6'd1));
    assign t_diff     = 7'(t_hi - t_lo);
    assign interp     = 17'(t_diff * frac);
    assign interp_rnd = {1'b0, interp} + 18'd512;
    assign oct        = $signed({2'b00, lead}) - 6'sd15;
    assign db_oct     = 17'(oct) * $signed({6'd0, OCTAVE_DB});
    assign db_sum     = db_oct + $signed({6'd0, t_lo}) + $signed({9'd0, interp_rnd[17:10]});
    assign db         = (level == '0) ? DB_FLOOR : 16'(db_sum);

endmodule

[design/pmdb_hold.sv]
module pmdb_hold #(
    parameter int CHANNELS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  pmdb_pkg::falloff_t  cfg_wr_data,
    input  pmdb_pkg::band_t     channel,
    input  pmdb_pkg::db_t       db_new,
    input  logic                update,
    output pmdb_pkg::db_t       held_db
);
    import pmdb_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    db_t             held_reg [CHANNELS];
    falloff_t        falloff_reg;
    logic [CH_W-1:0] ch_idx;
    logic            ch_ok;
    db_t             held_cur;
    logic signed [16:0] lim;

    assign ch_idx   = CH_W'(channel);
    assign ch_ok    = 32'(channel) < CHANNELS;
    assign held_cur = ch_ok ? held_reg[ch_idx] : DB_FLOOR;
    assign lim      = 17'(held_cur) - $signed({3'b000, falloff_reg});

    always_comb begin
        held_db = db_new;
        if (db_new < held_cur && lim > 17'(db_new)) begin
            held_db = 16'(lim);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            falloff_reg <= FALLOFF_RESET;
        end else if (cfg_wr_en) begin
            falloff_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                held_reg[i] <= DB_FLOOR;
            end
        end else if (update && ch_ok) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (ch_idx == CH_W'(i)) begin
                    held_reg[i] <= held_db;
                end
            end
        end
    end

endmodule

[design/pmdb_curve.sv]
module pmdb_curve (
    input  pmdb_pkg::db_t   db,
    output pmdb_pkg::defl_t deflection
);
    import pmdb_pkg::*;

    logic signed [17:0] ds;
    logic signed [17:0] pct;
    logic        [22:0] num;
    logic        [46:0] prod;

    assign ds = 18'(db);

    always_comb begin
        if (ds < -18'sd17920) begin
            pct = '0;
        end else if (ds < -18'sd15360) begin
            pct = ds + 18'sd17920;
        end else if (ds < -18'sd12800) begin
            pct = 18'sd2 * (ds + 18'sd15360) + 18'sd2560;
        end else if (ds < -18'sd10240) begin
            pct = 18'sd3 * (ds + 18'sd12800) + 18'sd7680;
        end else if (ds < -18'sd7680) begin
            pct = 18'sd6 * (ds + 18'sd10240) + 18'sd15360;
        end else if (ds < -18'sd5120) begin
            pct = 18'sd8 * (ds + 18'sd7680) + 18'sd30720;
        end else if (ds < 18'sd1536) begin
            pct = 18'sd10 * (ds + 18'sd5120) + 18'sd51200;
        end else begin
            pct = 18'sd117760;
        end
    end

    assign num        = {pct[16:0], 6'd0} + 23'(ROUND_115);
    assign prod       = 47'(num) * 47'(DIV230_MULT);
    assign deflection = prod[DIV230_SHIFT +: 16];

endmodule

[design/peak_meter_db_falloff.sv]
// Channel     | Dir | Payload
// s_ (in)     | in  | tuser: channel[2:0]; tdata: level[15:0]
// m_ (out)    | out | tuser: band[2:0]; tdata: deflection[15:0], held_db[31:16]
// cfg_wr_     | in  | falloff_step[13:0], written when cfg_wr_en is high
//
// One beat per cycle in and out while m_tready stays high; each result passes
// through the input register, the dB/falloff register and the output register.
// Each held peak updates as its beat leaves the input register, so back-to-back
// beats on one channel see the previous update without a bubble.
// aresetn (synchronous) sets all held peaks to -128 dB and falloff_step to 1336.
// m_tready low stalls the pipeline stage by stage; s_tready drops only when
// the input register is full and cannot move on.
module peak_meter_db_falloff #(
    parameter int CHANNELS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  pmdb_pkg::falloff_t  cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // level[15:0]
    input  logic [2:0]          s_tuser,   // channel[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // deflection[15:0], held_db[31:16]
    output logic [2:0]          m_tuser    // band[2:0]
);
    import pmdb_pkg::*;

    logic       in_v_reg;
    band_t      in_ch_reg;
    level_t     in_lvl_reg;
    logic       mid_v_reg;
    pmdb_beat_t mid_reg;
    logic       out_v_reg;
    band_t      out_band_reg;
    defl_t      out_defl_reg;
    db_t        out_db_reg;

    logic       adv_out;
    logic       adv_mid;
    logic       s_take;
    db_t        db_lin;
    db_t        db_held;
    defl_t      defl;

    assign adv_out  = mid_v_reg && (!out_v_reg || m_tready);
    assign adv_mid  = in_v_reg && (!mid_v_reg || adv_out);
    assign s_tready = !in_v_reg || adv_mid;
    assign s_take   = s_tvalid && s_tready;

    pmdb_log u_log (
        .level (in_lvl_reg),
        .db    (db_lin)
    );

    pmdb_hold #(
        .CHANNELS (CHANNELS)
    ) u_hold (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .channel     (in_ch_reg),
        .db_new      (db_lin),
        .update      (adv_mid),
        .held_db     (db_held)
    );

    pmdb_curve u_curve (
        .db         (mid_reg.held_db),
        .deflection (defl)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            mid_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (s_take) begin
                in_v_reg <= 1'b1;
            end else if (adv_mid) begin
                in_v_reg <= 1'b0;
            end
            if (adv_mid) begin
                mid_v_reg <= 1'b1;
            end else if (adv_out) begin
                mid_v_reg <= 1'b0;
            end
            if (adv_out) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_ch_reg  <= s_tuser;
            in_lvl_reg <= s_tdata;
        end
        if (adv_mid) begin
            mid_reg.band    <= in_ch_reg;
            mid_reg.held_db <= db_held;
        end
        if (adv_out) begin
            out_band_reg <= mid_reg.band;
            out_defl_reg <= defl;
            out_db_reg   <= mid_reg.held_db;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_db_reg, out_defl_reg};
    assign m_tuser  = out_band_reg;

`ifndef SYNTH
    a_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] <= 16'd32768)
        else $error("deflection above full scale");

    a_floor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:16] == DB_FLOOR |-> m_tdata[15:0] == 16'd0)
        else $error("silence floor gives nonzero deflection");

    a_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_v_reg && mid_v_reg && out_v_reg && !m_tready)
        else $error("input stalled while pipeline has room");

    a_mid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_v_reg && !adv_out |=> mid_v_reg && $stable(mid_reg))
        else $error("middle stage lost or changed a stalled beat");
`endif

endmodule

[sim/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pmdb_pkg::*;

    localparam int CHANNELS   = 5;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        band_t band;
        defl_t deflection;
        db_t   held_db;
    } meter_beat_t;

    class peak_meter_sb;
        int          held[CHANNELS];
        int          step;
        int          errors;
        meter_beat_t deflections_due[$];

        function new();
            foreach (held[i]) held[i] = int'(DB_FLOOR);
            step   = int'(FALLOFF_RESET);
            errors = 0;
        endfunction

        function void set_falloff(falloff_t v);
            step = int'(v);
        endfunction

        function int pending();
            return deflections_due.size();
        endfunction

        function int level_db(level_t v);
            int mant[33] = '{0, 68, 135, 199, 262, 323, 382, 440,
                             496, 551, 605, 657, 708, 758, 807, 855,
                             902, 947, 992, 1036, 1080, 1122, 1163, 1204,
                             1244, 1284, 1322, 1360, 1398, 1435, 1471, 1506,
                             1541};
            int          e;
            logic [15:0] m;
            int          idx;
            int          r;
            if (v == 16'd0) return int'(DB_FLOOR);
            e = 15;
            while (e > 0 && v[e] == 1'b0) e--;
            m   = v << (15 - e);
            idx = int'(m[14:10]);
            r   = int'(m[9:0]);
            return (e - 15) * 1541 + mant[idx]
                + (((mant[idx + 1] - mant[idx]) * r + 512) >>> 10);
        endfunction

        function int deflection_of(int d);
            int p;
            if (d < -17920)      p = 0;
            else if (d < -15360) p = d + 17920;
            else if (d < -12800) p = 2 * (d + 15360) + 2560;
            else if (d < -10240) p = 3 * (d + 12800) + 7680;
            else if (d < -7680)  p = 6 * (d + 10240) + 15360;
            else if (d < -5120)  p = 8 * (d + 7680) + 30720;
            else if (d < 1536)   p = 10 * (d + 5120) + 51200;
            else                 p = 117760;
            return (p * 64 + 115) / 230;
        endfunction

        function void take_level(band_t ch, level_t lvl);
            meter_beat_t b;
            int          prev;
            int          db;
            int          lim;
            prev = (ch < CHANNELS) ? held[ch] : int'(DB_FLOOR);
            db   = level_db(lvl);
            if (db < prev) begin
                lim = prev - step;
                if (lim > db) db = lim;
            end
            if (ch < CHANNELS) held[ch] = db;
            b.band       = ch;
            b.deflection = defl_t'(deflection_of(db));
            b.held_db    = db_t'(db);
            deflections_due.push_back(b);
        endfunction

        function void check_deflection(band_t band, defl_t defl, db_t hdb);
            meter_beat_t b;
            if (deflections_due.size() == 0) begin
                $error("unexpected result beat: band %0d deflection %0d held_db %0d",
                       band, defl, hdb);
                errors++;
                return;
            end
            b = deflections_due.pop_front();
            if (band !== b.band) begin
                $error("band mismatch: expected %0d got %0d", b.band, band);
                errors++;
            end
            if (defl !== b.deflection) begin
                $error("deflection mismatch: expected %0d got %0d", b.deflection, defl);
                errors++;
            end
            if (hdb !== b.held_db) begin
                $error("held_db mismatch: expected %0d got %0d", b.held_db, hdb);
                errors++;
            end
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    falloff_t    cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic [2:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    peak_meter_sb meter_sb = new();

    int tx_max  = 0;
    int rx_max  = 0;
    bit rx_hold = 1'b0;
    int idle_cycles = 0;

    peak_meter_db_falloff #(
        .CHANNELS (CHANNELS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                meter_sb.take_level(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                meter_sb.check_deflection(m_tuser, m_tdata[15:0], m_tdata[31:16]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : receiver
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end
            gap = (rx_max > 0) ? $urandom_range(0, rx_max) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_level(input band_t ch, input level_t lvl);
        int gap;
        gap = (tx_max > 0) ? $urandom_range(0, tx_max) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lvl;
        s_tuser  <= ch;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (meter_sb.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_falloff(input falloff_t v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        meter_sb.set_falloff(v);
    endtask

    function automatic level_t rand_level();
        int sel;
        int sh;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'd0;
        if (sel <= 4) return level_t'($urandom_range(0, 65535));
        sh = $urandom_range(0, 15);
        return level_t'(($urandom & ((32'd1 << sh) - 1)) | (32'd1 << sh));
    endfunction

    function automatic band_t rand_band();
        if ($urandom_range(0, 99) < 85) return band_t'($urandom_range(0, CHANNELS - 1));
        return band_t'($urandom_range(CHANNELS, 7));
    endfunction

    initial begin : stimulus
        int phase_step[6];
        int phase_tx[6];
        int phase_rx[6];
        phase_step = '{0, 16383, 64, 0, 1336, 256};
        phase_tx   = '{12, 0, 0, 12, 12, 3};
        phase_rx   = '{12, 0, 12, 0, 12, 3};
        phase_step[3] = $urandom_range(0, 16383);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full scale then let it fall off at the reset step
        send_level(3'd0, 16'd65535);
        send_level(3'd0, 16'd0);
        send_level(3'd0, 16'd0);
        send_level(3'd0, 16'd0);
        send_level(3'd0, 16'd32768);
        send_level(3'd1, 16'd1);
        send_level(3'd1, 16'd2);
        send_level(3'd1, 16'd3);
        send_level(3'd1, 16'd32767);
        // one level per curve segment
        send_level(3'd2, 16'd5);
        send_level(3'd2, 16'd20);
        send_level(3'd2, 16'd60);
        send_level(3'd2, 16'd200);
        send_level(3'd2, 16'd600);
        send_level(3'd2, 16'd2000);
        send_level(3'd2, 16'd10000);
        send_level(3'd2, 16'd65400);
        // out-of-range bands, then a silent beat on band 4
        send_level(3'd5, 16'd1000);
        send_level(3'd6, 16'd65535);
        send_level(3'd7, 16'd0);
        send_level(3'd4, 16'd0);
        drain();

        // falloff reaching below the silence floor
        write_falloff(14'd16383);
        send_level(3'd3, 16'd1);
        send_level(3'd3, 16'd0);
        send_level(3'd3, 16'd0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_falloff(falloff_t'(phase_step[ph]));
            tx_max = phase_tx[ph];
            rx_max = phase_rx[ph];
            if (ph == 2) begin
                rx_hold = 1'b1;
                for (int i = 0; i < 40; i++) send_level(rand_band(), rand_level());
            end
            for (int i = 0; i < 80; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_level(rand_band(), 16'd65535);
                    for (int k = 0; k < 4; k++) send_level(rand_band(), 16'd0);
                end else begin
                    send_level(rand_band(), rand_level());
                end
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        if (meter_sb.errors == 0 && meter_sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
